@@ rtl/core/bafu_pkg.sv @@
// ----------------------------------------------------------------------------
// bafu_pkg - shared types for the binary array field unpacker
// Item structs, slot descriptor and slot write port, queue sizing.
// ----------------------------------------------------------------------------
package bafu_pkg;

  localparam int MAX_SLOT_BYTES_DEF = 64;
  localparam int QDEPTH             = 2;
  localparam int SLOTW              = 7;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [6:0]  slot_bytes;
    logic        is_array;
    logic        is_string;
    logic [31:0] scalar_len;
  } in_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       slot_last;
    logic       field_last;
  } out_item_t;

  typedef struct packed {
    logic             empty;
    logic [SLOTW-1:0] width;
    logic [SLOTW-1:0] count;
    logic             swap;
    logic             last;
  } slot_desc_t;

  typedef struct packed {
    logic             en;
    logic [SLOTW-1:0] idx;
    logic [7:0]       data;
  } slot_wr_t;

  function automatic logic slot_swap(logic [SLOTW-1:0] w, logic is_str);
    return !is_str && (w == 7'd2 || w == 7'd4 || w == 7'd8);
  endfunction

endpackage

@@ rtl/core/bafu_front.sv @@
// ----------------------------------------------------------------------------
// bafu_front - field parser
// Accepts items, walks the array header, collects slot bytes and pushes one
// slot descriptor per element, scalar or empty field.
// ----------------------------------------------------------------------------
module bafu_front #(
  parameter int MAX_SLOT_BYTES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bafu_pkg::in_item_t   in_item,
  input  logic                 q_full,
  output logic                 push,
  output bafu_pkg::slot_desc_t push_desc,
  output bafu_pkg::slot_wr_t   wr
);
  import bafu_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_NDIM, PH_SKIP, PH_DIM, PH_DIMSKIP, PH_ELEMLEN, PH_ELEMDATA
  } phase_t;

  localparam logic [SLOTW-1:0] MAX_W = SLOTW'(MAX_SLOT_BYTES);

  phase_t           phase, phase_next;
  logic [3:0]       header_count, header_count_next;
  logic [31:0]      dims_left, dims_left_next;
  logic [31:0]      elems_left, elems_left_next;
  logic [31:0]      word_shift, word_shift_next;
  logic [31:0]      elem_len, elem_len_next;
  logic [31:0]      elem_received, elem_received_next;
  logic [31:0]      number_buffer, number_buffer_next;
  logic [SLOTW-1:0] width, width_next;
  logic             is_array, is_array_next;
  logic             is_string, is_string_next;

  logic             accept;
  logic [31:0]      acc_word;
  logic [3:0]       hc_inc;
  logic [63:0]      prod_full;
  logic [31:0]      elems_dec;
  logic [31:0]      recv_inc;
  logic [SLOTW-1:0] width_clamped;
  logic             do_finish;
  logic             do_empty;
  logic [SLOTW-1:0] fin_count;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign acc_word  = {number_buffer[23:0], in_item.data_byte};
  assign hc_inc    = header_count + 4'd1;
  assign prod_full = 64'(word_shift) * 64'(acc_word);
  assign elems_dec = elems_left - 32'd1;
  assign recv_inc  = elem_received + 32'd1;

  always_comb begin
    if (in_item.slot_bytes == '0) begin
      width_clamped = SLOTW'(1);
    end else if (in_item.slot_bytes > MAX_W) begin
      width_clamped = MAX_W;
    end else begin
      width_clamped = in_item.slot_bytes;
    end
  end

  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    dims_left_next     = dims_left;
    elems_left_next    = elems_left;
    word_shift_next    = word_shift;
    elem_len_next      = elem_len;
    elem_received_next = elem_received;
    number_buffer_next = number_buffer;
    width_next         = width;
    is_array_next      = is_array;
    is_string_next     = is_string;
    push               = 1'b0;
    push_desc          = '0;
    wr                 = '0;
    do_finish          = 1'b0;
    do_empty           = 1'b0;
    fin_count          = '0;

    if (accept) begin
      if (!in_item.kind) begin
        header_count_next  = '0;
        dims_left_next     = '0;
        elems_left_next    = '0;
        word_shift_next    = '0;
        elem_len_next      = '0;
        elem_received_next = '0;
        number_buffer_next = '0;
        width_next         = width_clamped;
        is_array_next      = in_item.is_array;
        is_string_next     = in_item.is_string;
        if (in_item.is_array) begin
          phase_next = PH_NDIM;
        end else if (in_item.scalar_len == '0 || in_item.scalar_len[31]) begin
          push            = 1'b1;
          push_desc.width = width_clamped;
          push_desc.swap  = slot_swap(width_clamped, in_item.is_string);
          push_desc.last  = 1'b1;
          phase_next      = PH_IDLE;
        end else begin
          elems_left_next = 32'd1;
          elem_len_next   = in_item.scalar_len;
          phase_next      = PH_ELEMDATA;
        end
      end else begin
        case (phase)
          PH_NDIM: begin
            number_buffer_next = acc_word;
            header_count_next  = hc_inc;
            if (hc_inc == 4'd4) begin
              dims_left_next    = acc_word;
              header_count_next = '0;
              phase_next        = PH_SKIP;
            end
          end
          PH_SKIP: begin
            header_count_next = hc_inc;
            if (hc_inc == 4'd8) begin
              header_count_next  = '0;
              number_buffer_next = '0;
              if (dims_left == '0 || dims_left[31]) begin
                do_empty = 1'b1;
              end else begin
                word_shift_next = 32'd1;
                phase_next      = PH_DIM;
              end
            end
          end
          PH_DIM: begin
            number_buffer_next = acc_word;
            header_count_next  = hc_inc;
            if (hc_inc == 4'd4) begin
              word_shift_next   = prod_full[31:0];
              header_count_next = '0;
              phase_next        = PH_DIMSKIP;
            end
          end
          PH_DIMSKIP: begin
            header_count_next = hc_inc;
            if (hc_inc == 4'd4) begin
              header_count_next  = '0;
              number_buffer_next = '0;
              dims_left_next     = dims_left - 32'd1;
              if (dims_left != 32'd1) begin
                phase_next = PH_DIM;
              end else if (word_shift == '0 || word_shift[31]) begin
                do_empty = 1'b1;
              end else begin
                elems_left_next = word_shift;
                phase_next      = PH_ELEMLEN;
              end
            end
          end
          PH_ELEMLEN: begin
            number_buffer_next = acc_word;
            header_count_next  = hc_inc;
            if (hc_inc == 4'd4) begin
              header_count_next  = '0;
              number_buffer_next = '0;
              if (acc_word == '0 || acc_word[31]) begin
                elem_len_next = '0;
                do_finish     = 1'b1;
              end else begin
                elem_len_next      = acc_word;
                elem_received_next = '0;
                phase_next         = PH_ELEMDATA;
              end
            end
          end
          PH_ELEMDATA: begin
            if (elem_received < {25'd0, width}) begin
              wr.en   = 1'b1;
              wr.idx  = elem_received[SLOTW-1:0];
              wr.data = in_item.data_byte;
            end
            elem_received_next = recv_inc;
            if (recv_inc == elem_len) begin
              do_finish = 1'b1;
              fin_count = (elem_len < {25'd0, width}) ? elem_len[SLOTW-1:0] : width;
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (do_finish) begin
      push            = 1'b1;
      push_desc.width = width;
      push_desc.count = fin_count;
      push_desc.swap  = slot_swap(width, is_string);
      push_desc.last  = !is_array || elems_dec == '0;
      elems_left_next = elems_dec;
      if (!is_array || elems_dec == '0) begin
        phase_next = PH_IDLE;
      end else begin
        phase_next         = PH_ELEMLEN;
        header_count_next  = '0;
        number_buffer_next = '0;
      end
    end

    if (do_empty) begin
      push            = 1'b1;
      push_desc.empty = 1'b1;
      push_desc.last  = 1'b1;
      phase_next      = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      header_count  <= '0;
      dims_left     <= '0;
      elems_left    <= '0;
      word_shift    <= '0;
      elem_len      <= '0;
      elem_received <= '0;
      number_buffer <= '0;
      width         <= '0;
      is_array      <= 1'b0;
      is_string     <= 1'b0;
    end else begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      dims_left     <= dims_left_next;
      elems_left    <= elems_left_next;
      word_shift    <= word_shift_next;
      elem_len      <= elem_len_next;
      elem_received <= elem_received_next;
      number_buffer <= number_buffer_next;
      width         <= width_next;
      is_array      <= is_array_next;
      is_string     <= is_string_next;
    end
  end

endmodule

@@ rtl/core/bafu_queue.sv @@
// ----------------------------------------------------------------------------
// bafu_queue - slot queue
// Descriptor FIFO with one slot-data bank per entry in a 1W1R memory.
// ----------------------------------------------------------------------------
module bafu_queue #(
  parameter int MAX_SLOT_BYTES = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  bafu_pkg::slot_desc_t              push_desc,
  input  bafu_pkg::slot_wr_t                wr,
  input  logic                              pop,
  input  logic                              rd_en,
  input  logic [$clog2(MAX_SLOT_BYTES)-1:0] rd_idx,
  output logic [7:0]                        rd_data,
  output bafu_pkg::slot_desc_t              head_desc,
  output logic                              full,
  output logic                              empty
);
  import bafu_pkg::*;

  localparam int IW        = $clog2(MAX_SLOT_BYTES);
  localparam int PW        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW        = $clog2(QDEPTH + 1);
  localparam int MEM_DEPTH = QDEPTH * (1 << IW);

  logic [7:0]  mem [MEM_DEPTH];
  slot_desc_t  desc_q [QDEPTH];
  logic [PW-1:0] head, tail;
  logic [CW-1:0] count;

  assign full      = count == CW'(QDEPTH);
  assign empty     = count == '0;
  assign head_desc = desc_q[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PW'(QDEPTH - 1)) ? '0 : tail + PW'(1);
      end
      if (pop) begin
        head <= (head == PW'(QDEPTH - 1)) ? '0 : head + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      desc_q[tail] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[{tail, wr.idx[IW-1:0]}] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[{head, rd_idx}];
    end
  end

endmodule

@@ rtl/core/bafu_back.sv @@
// ----------------------------------------------------------------------------
// bafu_back - slot emitter
// Walks the head slot one byte per cycle unless the output stalls, reverses
// it when swap is set, zero-fills it, and drives the result register.
// ----------------------------------------------------------------------------
module bafu_back #(
  parameter int MAX_SLOT_BYTES = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  bafu_pkg::slot_desc_t              head_desc,
  input  logic [7:0]                        rd_data,
  output logic                              pop,
  output logic                              rd_en,
  output logic [$clog2(MAX_SLOT_BYTES)-1:0] rd_idx,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bafu_pkg::out_item_t               out_item
);
  import bafu_pkg::*;

  localparam int IW = $clog2(MAX_SLOT_BYTES);

  typedef struct packed {
    logic byte_valid;
    logic zero;
    logic slot_last;
    logic field_last;
  } s1_meta_t;

  logic [IW-1:0]    k;
  logic [SLOTW-1:0] k7, w_m1, src7;
  logic             issue, load1, adv2, at_end, zero;
  logic             s1_valid;
  s1_meta_t         s1_meta;

  assign k7     = SLOTW'(k);
  assign w_m1   = head_desc.width - SLOTW'(1);
  assign src7   = head_desc.swap ? w_m1 - k7 : k7;
  assign zero   = src7 >= head_desc.count;
  assign at_end = head_desc.empty || k7 == w_m1;
  assign adv2   = !out_valid || out_ready;
  assign load1  = !s1_valid || adv2;
  assign issue  = !q_empty && load1;
  assign pop    = issue && at_end;
  assign rd_en  = issue && !head_desc.empty;
  assign rd_idx = src7[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        k <= at_end ? '0 : k + IW'(1);
      end
      if (load1) begin
        s1_valid <= issue;
      end
      if (adv2) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_meta.byte_valid <= !head_desc.empty;
      s1_meta.zero       <= head_desc.empty || zero;
      s1_meta.slot_last  <= !head_desc.empty && k7 == w_m1;
      s1_meta.field_last <= head_desc.last && at_end;
    end
    if (adv2 && s1_valid) begin
      out_item.byte_valid <= s1_meta.byte_valid;
      out_item.out_byte   <= s1_meta.zero ? 8'd0 : rd_data;
      out_item.slot_last  <= s1_meta.slot_last;
      out_item.field_last <= s1_meta.field_last;
    end
  end

endmodule

@@ rtl/core/binary_array_field_unpacker.sv @@
// ----------------------------------------------------------------------------
// binary_array_field_unpacker - top level
// Unpacks a binary array or scalar column value into fixed-width slots.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    in_item  (field start or data byte)
//   out      out_valid / out_ready  out_item (one slot byte or empty marker)
//
// One input item per cycle while the slot queue has a free entry.
// Each slot drains as width results, one per unstalled cycle, via the emitter;
// narrow elements in wide slots are paced by that emitter and its queue.
// A slot's first result goes through the queue, read stage and result register.
// Reset clears control state; slot memory needs no clearing.
// A stalled output holds the emitter; the parser runs on until the queue fills.
// ----------------------------------------------------------------------------
module binary_array_field_unpacker #(
  parameter int MAX_SLOT_BYTES = bafu_pkg::MAX_SLOT_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bafu_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output bafu_pkg::out_item_t out_item
);
  import bafu_pkg::*;

  localparam int IW = $clog2(MAX_SLOT_BYTES);

  logic          q_full, q_empty, push, pop, rd_en;
  slot_desc_t    push_desc, head_desc;
  slot_wr_t      wr;
  logic [IW-1:0] rd_idx;
  logic [7:0]    rd_data;

  bafu_front #(.MAX_SLOT_BYTES(MAX_SLOT_BYTES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc),
    .wr        (wr)
  );

  bafu_queue #(.MAX_SLOT_BYTES(MAX_SLOT_BYTES)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .wr        (wr),
    .pop       (pop),
    .rd_en     (rd_en),
    .rd_idx    (rd_idx),
    .rd_data   (rd_data),
    .head_desc (head_desc),
    .full      (q_full),
    .empty     (q_empty)
  );

  bafu_back #(.MAX_SLOT_BYTES(MAX_SLOT_BYTES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head_desc (head_desc),
    .rd_data   (rd_data),
    .pop       (pop),
    .rd_en     (rd_en),
    .rd_idx    (rd_idx),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("slot pushed into a full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (rst) pop |-> !q_empty)
    else $error("slot popped from an empty queue");

  a_marker: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_item.byte_valid |->
      out_item.field_last && !out_item.slot_last && out_item.out_byte == 8'd0)
    else $error("empty marker malformed");

  a_field_end: assert property (@(posedge clk) disable iff (rst)
      out_valid && out_item.byte_valid && out_item.field_last |-> out_item.slot_last)
    else $error("field ended inside a slot");

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule
